// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// same-cycle implication, sampled on clk, off during reset
`define LDC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define LDC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== rtl/ldc_pkg.sv =====
// Shared types, constants and state encodings for the divergence curve block.
package ldc_pkg;

  localparam int SAMPLES  = 1024;
  localparam int AW       = 10;
  localparam int CW       = 11;
  localparam int SW       = 16;
  localparam int MAX_DIM  = 8;
  localparam int DIST_W   = 36;
  localparam int LN_W     = 20;
  localparam int ACC_W    = 30;
  localparam int CFG_W    = 8;

  localparam logic [29:0] LN2_Q30  = 30'd744261118;
  localparam logic [12:0] RECIP10  = 13'd6554;
  localparam logic [19:0] MEAN_MAX = 20'hFFFFF;

  localparam logic       OP_LOAD = 1'b0;
  localparam logic       OP_READ = 1'b1;
  localparam logic       CFG_LAG = 1'b0;
  localparam logic       CFG_DIM = 1'b1;
  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_ROW  = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  typedef struct packed {
    logic                 op;
    logic signed [SW-1:0] sample;
    logic                 last_sample;
    logic [AW-1:0]        row_select;
  } in_req_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [CW-1:0]   vector_count;
    logic [CW-1:0]   row_number;
    logic [AW-1:0]   neighbour_index;
    logic [LN_W-1:0] mean_log_divergence;
  } out_rsp_t;

  typedef enum logic [4:0] {
    S_IDLE, S_READ, S_SETUP, S_CHECK, S_FAIL,
    S_NN_ROW, S_NN_J, S_NA, S_NS, S_NC, S_NN_CMP, S_NN_WR,
    S_DV_ROW, S_DV_NB, S_DV_K, S_VA, S_VS, S_VC, S_DV_CHK, S_DV_LOG, S_DV_UPD,
    S_MN_RD, S_MN_DIV, S_MN_WAIT, S_DONE
  } state_t;

  typedef enum logic [2:0] {
    LG_IDLE, LG_NORM, LG_SQ, LG_MUL1, LG_MUL2
  } lg_state_t;

  typedef struct packed {
    logic ld_sample;
    logic setup;
    logic phase_dv;
    logic i_clr;
    logic i_inc;
    logic j_clr;
    logic j_inc;
    logic d_clr;
    logic d_acc;
    logic nn_take;
    logic nn_wr;
    logic dv_nb;
    logic k_step;
    logic log_go;
    logic acc_upd;
    logic mn_init;
    logic mn_next;
    logic div_go;
    logic div_wr0;
    logic div_wr;
    logic fin_ok;
    logic fin_bad;
    logic rsp_done;
    logic rsp_fail;
    logic rsp_row;
  } cmd_t;

  typedef struct packed {
    logic few;
    logic j_end;
    logic excl;
    logic dim_last;
    logic better;
    logic i_last;
    logic pair_ok;
    logic dist_zero;
    logic log_done;
    logic cnt_zero;
    logic k_last;
    logic div_done;
  } sts_t;

endpackage

// ===== rtl/lyapunov_divergence_curve.sv =====
// Top level: largest-Lyapunov divergence curve, controller plus datapath.
// Sample load: no result. Row read: result in the cycle after the request; no new request
//   is taken while that result is shown.
// Last sample: setup and a vector-count check (error result if too few), the neighbour search,
//   the divergence pass with a log per positive distance, then a mean per row, divided where its count is nonzero.
// Busy stays high for the whole computation; one result strobe, receiver cannot stall.
// Synchronous active-low reset clears the state and control registers; working registers and memories are not cleared.
module lyapunov_divergence_curve (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  ldc_pkg::in_req_t           in_req,
  output logic                       out_valid,
  output ldc_pkg::out_rsp_t          out_rsp,
  input  logic                       cfg_we,
  input  logic                       cfg_idx,
  input  logic [ldc_pkg::CFG_W-1:0]  cfg_data
);

  ldc_pkg::cmd_t cmd;
  ldc_pkg::sts_t sts;

  ldc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .op         (in_req.op),
    .last_sample(in_req.last_sample),
    .sts        (sts),
    .cmd        (cmd),
    .busy       (busy),
    .out_valid  (out_valid)
  );

  ldc_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .cfg_we  (cfg_we),
    .cfg_idx (cfg_idx),
    .cfg_data(cfg_data),
    .cmd     (cmd),
    .sts     (sts),
    .out_rsp (out_rsp)
  );

endmodule

// ===== rtl/ldc_log.sv =====
// Iterative ln(sqrt(S)) unit: normalize, 28 squaring steps, scale by ln2.
module ldc_log (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          go,
  input  logic [ldc_pkg::DIST_W-1:0]    s_in,
  output logic                          done,
  output logic [ldc_pkg::LN_W-1:0]      res
);

  ldc_pkg::lg_state_t state_r, state_nxt;
  logic [ldc_pkg::DIST_W-1:0] s_r;
  logic [5:0]  e_r;
  logic [30:0] m_r;
  logic [27:0] frac_r;
  logic [4:0]  cnt_r;
  logic [57:0] p_r;
  logic [61:0] sq;
  logic [31:0] t;
  logic [63:0] tot;
  logic        norm_end;

  assign sq       = 62'(m_r) * 62'(m_r);
  assign t        = sq[61:30];
  assign norm_end = s_r[ldc_pkg::DIST_W-1] || (e_r == 6'd0);
  assign tot      = 64'(p_r) + ((64'(e_r) * 64'(ldc_pkg::LN2_Q30)) << 28) + (64'd1 << 42);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ldc_pkg::LG_IDLE: if (go) state_nxt = ldc_pkg::LG_NORM;
      ldc_pkg::LG_NORM: if (norm_end) state_nxt = ldc_pkg::LG_SQ;
      ldc_pkg::LG_SQ:   if (cnt_r == 5'd27) state_nxt = ldc_pkg::LG_MUL1;
      ldc_pkg::LG_MUL1: state_nxt = ldc_pkg::LG_MUL2;
      ldc_pkg::LG_MUL2: state_nxt = ldc_pkg::LG_IDLE;
      default:          state_nxt = ldc_pkg::LG_IDLE;
    endcase
  end

  always_comb begin
    done = (state_r == ldc_pkg::LG_MUL2);
    res  = tot[62:43];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ldc_pkg::LG_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ldc_pkg::LG_IDLE: begin
        s_r <= s_in;
        e_r <= 6'(ldc_pkg::DIST_W - 1);
      end
      ldc_pkg::LG_NORM: begin
        if (!norm_end) begin
          s_r <= s_r << 1;
          e_r <= e_r - 6'd1;
        end else begin
          m_r    <= s_r[ldc_pkg::DIST_W-1 -: 31];
          frac_r <= '0;
          cnt_r  <= '0;
        end
      end
      ldc_pkg::LG_SQ: begin
        frac_r <= {frac_r[26:0], t[31]};
        m_r    <= t[31] ? t[31:1] : t[30:0];
        cnt_r  <= cnt_r + 5'd1;
      end
      ldc_pkg::LG_MUL1: p_r <= 58'(frac_r) * 58'(ldc_pkg::LN2_Q30);
      default: ;
    endcase
  end

endmodule

// ===== rtl/ldc_div.sv =====
// Restoring divider, one quotient bit per cycle, for the per-row mean.
module ldc_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       go,
  input  logic [ldc_pkg::ACC_W-1:0]  dividend,
  input  logic [ldc_pkg::CW-1:0]     divisor,
  output logic                       done,
  output logic [ldc_pkg::ACC_W-1:0]  quotient
);

  logic                      busy_r, done_r;
  logic [4:0]                cnt_r;
  logic [ldc_pkg::CW-1:0]    rem_r, dvs_r;
  logic [ldc_pkg::ACC_W-1:0] quo_r;
  logic [ldc_pkg::CW:0]      shl;
  logic                      ge;

  assign shl      = {rem_r, quo_r[ldc_pkg::ACC_W-1]};
  assign ge       = shl >= {1'b0, dvs_r};
  assign done     = done_r;
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == 5'(ldc_pkg::ACC_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
      cnt_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? ldc_pkg::CW'(shl - {1'b0, dvs_r}) : shl[ldc_pkg::CW-1:0];
      quo_r <= {quo_r[ldc_pkg::ACC_W-2:0], ge};
      cnt_r <= cnt_r + 5'd1;
    end
  end

endmodule

// ===== rtl/ldc_ctrl.sv =====
// Sequencer for load, neighbour search, divergence tracking, mean and readback.
module ldc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              op,
  input  logic              last_sample,
  input  ldc_pkg::sts_t     sts,
  output ldc_pkg::cmd_t     cmd,
  output logic              busy,
  output logic              out_valid
);

  ldc_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ldc_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ldc_pkg::S_IDLE: begin
        if (start && op == ldc_pkg::OP_READ) state_nxt = ldc_pkg::S_READ;
        else if (start && last_sample) state_nxt = ldc_pkg::S_SETUP;
      end
      ldc_pkg::S_READ:   state_nxt = ldc_pkg::S_IDLE;
      ldc_pkg::S_SETUP:  state_nxt = ldc_pkg::S_CHECK;
      ldc_pkg::S_CHECK:  state_nxt = sts.few ? ldc_pkg::S_FAIL : ldc_pkg::S_NN_ROW;
      ldc_pkg::S_FAIL:   state_nxt = ldc_pkg::S_IDLE;
      ldc_pkg::S_NN_ROW: state_nxt = ldc_pkg::S_NN_J;
      ldc_pkg::S_NN_J: begin
        if (sts.j_end) state_nxt = ldc_pkg::S_NN_WR;
        else if (!sts.excl) state_nxt = ldc_pkg::S_NA;
      end
      ldc_pkg::S_NA:     state_nxt = ldc_pkg::S_NS;
      ldc_pkg::S_NS:     state_nxt = ldc_pkg::S_NC;
      ldc_pkg::S_NC:     state_nxt = sts.dim_last ? ldc_pkg::S_NN_CMP : ldc_pkg::S_NA;
      ldc_pkg::S_NN_CMP: state_nxt = ldc_pkg::S_NN_J;
      ldc_pkg::S_NN_WR:  state_nxt = sts.i_last ? ldc_pkg::S_DV_ROW : ldc_pkg::S_NN_ROW;
      ldc_pkg::S_DV_ROW: state_nxt = sts.i_last ? ldc_pkg::S_MN_RD : ldc_pkg::S_DV_NB;
      ldc_pkg::S_DV_NB:  state_nxt = ldc_pkg::S_DV_K;
      ldc_pkg::S_DV_K:   state_nxt = sts.pair_ok ? ldc_pkg::S_VA : ldc_pkg::S_DV_ROW;
      ldc_pkg::S_VA:     state_nxt = ldc_pkg::S_VS;
      ldc_pkg::S_VS:     state_nxt = ldc_pkg::S_VC;
      ldc_pkg::S_VC:     state_nxt = sts.dim_last ? ldc_pkg::S_DV_CHK : ldc_pkg::S_VA;
      ldc_pkg::S_DV_CHK: state_nxt = sts.dist_zero ? ldc_pkg::S_DV_K : ldc_pkg::S_DV_LOG;
      ldc_pkg::S_DV_LOG: if (sts.log_done) state_nxt = ldc_pkg::S_DV_UPD;
      ldc_pkg::S_DV_UPD: state_nxt = ldc_pkg::S_DV_K;
      ldc_pkg::S_MN_RD:  state_nxt = ldc_pkg::S_MN_DIV;
      ldc_pkg::S_MN_DIV: begin
        if (!sts.cnt_zero) state_nxt = ldc_pkg::S_MN_WAIT;
        else state_nxt = sts.k_last ? ldc_pkg::S_DONE : ldc_pkg::S_MN_RD;
      end
      ldc_pkg::S_MN_WAIT: begin
        if (sts.div_done) state_nxt = sts.k_last ? ldc_pkg::S_DONE : ldc_pkg::S_MN_RD;
      end
      ldc_pkg::S_DONE:   state_nxt = ldc_pkg::S_IDLE;
      default:           state_nxt = ldc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      ldc_pkg::S_IDLE:   cmd.ld_sample = start && op == ldc_pkg::OP_LOAD;
      ldc_pkg::S_READ:   cmd.rsp_row = 1'b1;
      ldc_pkg::S_SETUP:  cmd.setup = 1'b1;
      ldc_pkg::S_CHECK:  cmd.i_clr = 1'b1;
      ldc_pkg::S_FAIL: begin
        cmd.rsp_fail = 1'b1;
        cmd.fin_bad  = 1'b1;
      end
      ldc_pkg::S_NN_ROW: cmd.j_clr = 1'b1;
      ldc_pkg::S_NN_J: begin
        cmd.j_inc = !sts.j_end && sts.excl;
        cmd.d_clr = !sts.j_end && !sts.excl;
      end
      ldc_pkg::S_NC:     cmd.d_acc = 1'b1;
      ldc_pkg::S_NN_CMP: begin
        cmd.nn_take = sts.better;
        cmd.j_inc   = 1'b1;
      end
      ldc_pkg::S_NN_WR: begin
        cmd.nn_wr = 1'b1;
        cmd.i_clr = sts.i_last;
        cmd.i_inc = !sts.i_last;
      end
      ldc_pkg::S_DV_ROW: begin
        cmd.phase_dv = 1'b1;
        cmd.mn_init  = sts.i_last;
      end
      ldc_pkg::S_DV_NB: begin
        cmd.phase_dv = 1'b1;
        cmd.dv_nb    = 1'b1;
      end
      ldc_pkg::S_DV_K: begin
        cmd.phase_dv = 1'b1;
        cmd.d_clr    = sts.pair_ok;
        cmd.i_inc    = !sts.pair_ok;
      end
      ldc_pkg::S_VA, ldc_pkg::S_VS: cmd.phase_dv = 1'b1;
      ldc_pkg::S_VC: begin
        cmd.phase_dv = 1'b1;
        cmd.d_acc    = 1'b1;
      end
      ldc_pkg::S_DV_CHK: begin
        cmd.phase_dv = 1'b1;
        cmd.k_step   = sts.dist_zero;
        cmd.log_go   = !sts.dist_zero;
      end
      ldc_pkg::S_DV_LOG: cmd.phase_dv = 1'b1;
      ldc_pkg::S_DV_UPD: begin
        cmd.phase_dv = 1'b1;
        cmd.acc_upd  = 1'b1;
        cmd.k_step   = 1'b1;
      end
      ldc_pkg::S_MN_DIV: begin
        cmd.div_go  = !sts.cnt_zero;
        cmd.div_wr0 = sts.cnt_zero;
        cmd.mn_next = sts.cnt_zero && !sts.k_last;
      end
      ldc_pkg::S_MN_WAIT: begin
        cmd.div_wr  = sts.div_done;
        cmd.mn_next = sts.div_done && !sts.k_last;
      end
      ldc_pkg::S_DONE: begin
        cmd.rsp_done = 1'b1;
        cmd.fin_ok   = 1'b1;
      end
      default: ;
    endcase
  end

  assign busy      = (state_r != ldc_pkg::S_IDLE);
  assign out_valid = cmd.rsp_done || cmd.rsp_fail || cmd.rsp_row;

endmodule

// ===== rtl/ldc_dp.sv =====
// Datapath: sample, neighbour, accumulator and result memories, index counters.
module ldc_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ldc_pkg::in_req_t            in_req,
  input  logic                        cfg_we,
  input  logic                        cfg_idx,
  input  logic [ldc_pkg::CFG_W-1:0]   cfg_data,
  input  ldc_pkg::cmd_t               cmd,
  output ldc_pkg::sts_t               sts,
  output ldc_pkg::out_rsp_t           out_rsp
);

  localparam int AW = ldc_pkg::AW;
  localparam int CW = ldc_pkg::CW;

  logic signed [ldc_pkg::SW-1:0]    smem [ldc_pkg::SAMPLES];
  logic [AW-1:0]                    nbmem [ldc_pkg::SAMPLES];
  logic [ldc_pkg::LN_W-1:0]         dvmem [ldc_pkg::SAMPLES];
  logic [ldc_pkg::ACC_W-1:0]        asmem [ldc_pkg::SAMPLES];
  logic [CW-1:0]                    acmem [ldc_pkg::SAMPLES];

  logic [7:0]            lag_r;
  logic [3:0]            dim_r;
  logic [CW-1:0]         cnt_r, vv_r;
  logic signed [12:0]    mv_r;
  logic [7:0]            rad_r;
  logic [CW-1:0]         i_r, j_r, k_r, a_r, b_r, off_r;
  logic [2:0]            dcnt_r;
  logic signed [ldc_pkg::SW-1:0] qa_r, qb_r;
  logic [33:0]           sq_r;
  logic [ldc_pkg::DIST_W-1:0] dist_r, best_r;
  logic [AW-1:0]         bi_r, nbq_r, row_r;
  logic                  found_r;
  logic [ldc_pkg::LN_W-1:0]  dvq_r;
  logic [ldc_pkg::ACC_W-1:0] asq_r;
  logic [CW-1:0]         acq_r;

  logic [2:0]            dims_m1;
  logic [CW-1:0]         m, span, gap, sa, sb;
  logic [CW:0]           a_off, b_off;
  logic signed [16:0]    diff;
  logic signed [33:0]    prod;
  logic [23:0]           rad_prod;
  logic                  log_done, div_done;
  logic [ldc_pkg::LN_W-1:0]  ln_res;
  logic [ldc_pkg::ACC_W-1:0] quo;
  logic [AW-1:0]         nb_raddr, acc_waddr;

  assign m       = mv_r[CW-1:0];
  assign dims_m1 = (dim_r == 4'd0) ? 3'd0 :
                   (dim_r > 4'(ldc_pkg::MAX_DIM)) ? 3'(ldc_pkg::MAX_DIM - 1) :
                   3'(dim_r - 4'd1);
  assign span     = CW'(dims_m1) * CW'(lag_r);
  assign rad_prod = (24'({lag_r, 3'b000}) + 24'd5) * 24'(ldc_pkg::RECIP10);
  assign gap      = (j_r > i_r) ? j_r - i_r : i_r - j_r;
  assign sa       = cmd.phase_dv ? a_r : i_r;
  assign sb       = cmd.phase_dv ? b_r : j_r;
  assign a_off    = {1'b0, sa} + {1'b0, off_r};
  assign b_off    = {1'b0, sb} + {1'b0, off_r};
  assign diff     = 17'(qa_r) - 17'(qb_r);
  assign prod     = 34'(diff) * 34'(diff);
  assign nb_raddr  = cmd.phase_dv ? i_r[AW-1:0] : in_req.row_select;
  assign acc_waddr = cmd.nn_wr ? i_r[AW-1:0] : k_r[AW-1:0];

  always_comb begin
    sts.few       = mv_r < 13'sd2;
    sts.j_end     = (j_r == m);
    sts.excl      = gap <= CW'(rad_r);
    sts.dim_last  = (dcnt_r == dims_m1);
    sts.better    = !found_r || (dist_r < best_r);
    sts.i_last    = (i_r == m - CW'(1));
    sts.pair_ok   = (a_r < m) && (b_r < m);
    sts.dist_zero = (dist_r == '0);
    sts.log_done  = log_done;
    sts.cnt_zero  = (acq_r == '0);
    sts.k_last    = (k_r == m - CW'(1));
    sts.div_done  = div_done;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lag_r <= 8'd1;
      dim_r <= 4'd2;
      cnt_r <= '0;
      vv_r  <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          ldc_pkg::CFG_LAG: lag_r <= cfg_data;
          ldc_pkg::CFG_DIM: dim_r <= cfg_data[3:0];
          default: ;
        endcase
      end
      if (cmd.ld_sample && !cnt_r[CW-1]) cnt_r <= cnt_r + CW'(1);
      if (cmd.fin_ok) begin
        vv_r  <= m;
        cnt_r <= '0;
      end
      if (cmd.fin_bad) begin
        vv_r  <= '0;
        cnt_r <= '0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      mv_r  <= $signed({2'b00, cnt_r}) - $signed({2'b00, span});
      rad_r <= rad_prod[23:16];
    end
    if (cmd.i_clr) i_r <= '0;
    if (cmd.i_inc) i_r <= i_r + CW'(1);
    if (cmd.j_clr) begin
      j_r     <= '0;
      found_r <= 1'b0;
      bi_r    <= '0;
    end
    if (cmd.j_inc) j_r <= j_r + CW'(1);
    if (cmd.d_clr) begin
      dist_r <= '0;
      off_r  <= '0;
      dcnt_r <= '0;
    end
    if (cmd.d_acc) begin
      dist_r <= dist_r + ldc_pkg::DIST_W'(sq_r);
      off_r  <= off_r + CW'(lag_r);
      dcnt_r <= dcnt_r + 3'd1;
    end
    if (cmd.nn_take) begin
      best_r  <= dist_r;
      bi_r    <= j_r[AW-1:0];
      found_r <= 1'b1;
    end
    if (cmd.dv_nb) begin
      a_r <= i_r + CW'(1);
      b_r <= {1'b0, nbq_r} + CW'(1);
      k_r <= '0;
    end
    if (cmd.k_step) begin
      a_r <= a_r + CW'(1);
      b_r <= b_r + CW'(1);
      k_r <= k_r + CW'(1);
    end
    if (cmd.mn_init) k_r <= '0;
    if (cmd.mn_next) k_r <= k_r + CW'(1);
    if (in_req.op == ldc_pkg::OP_READ) row_r <= in_req.row_select;
    sq_r <= prod[33:0];
  end

  // memories
  always_ff @(posedge clk) begin
    if (cmd.ld_sample && !cnt_r[CW-1]) smem[cnt_r[AW-1:0]] <= in_req.sample;
    qa_r <= smem[a_off[AW-1:0]];
    qb_r <= smem[b_off[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.nn_wr) nbmem[i_r[AW-1:0]] <= bi_r;
    nbq_r <= nbmem[nb_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.nn_wr || cmd.acc_upd) begin
      asmem[acc_waddr] <= cmd.nn_wr ? '0 : asq_r + ldc_pkg::ACC_W'(ln_res);
      acmem[acc_waddr] <= cmd.nn_wr ? '0 : acq_r + CW'(1);
    end
    asq_r <= asmem[k_r[AW-1:0]];
    acq_r <= acmem[k_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.div_wr0) dvmem[k_r[AW-1:0]] <= '0;
    if (cmd.div_wr) begin
      dvmem[k_r[AW-1:0]] <= (quo > ldc_pkg::ACC_W'(ldc_pkg::MEAN_MAX)) ?
                            ldc_pkg::MEAN_MAX : quo[ldc_pkg::LN_W-1:0];
    end
    dvq_r <= dvmem[in_req.row_select];
  end

  ldc_log u_log (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (cmd.log_go),
    .s_in (dist_r),
    .done (log_done),
    .res  (ln_res)
  );

  ldc_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (cmd.div_go),
    .dividend(asq_r),
    .divisor (acq_r),
    .done    (div_done),
    .quotient(quo)
  );

  always_comb begin
    out_rsp = '0;
    if (cmd.rsp_done) begin
      out_rsp.status       = ldc_pkg::ST_DONE;
      out_rsp.vector_count = m;
    end else if (cmd.rsp_fail) begin
      out_rsp.status       = ldc_pkg::ST_ERR;
      out_rsp.vector_count = (mv_r < 13'sd0) ? '0 : m;
    end else if (cmd.rsp_row) begin
      out_rsp.vector_count = vv_r;
      if ({1'b0, row_r} >= vv_r) begin
        out_rsp.status = ldc_pkg::ST_ERR;
      end else begin
        out_rsp.status              = ldc_pkg::ST_ROW;
        out_rsp.row_number          = {1'b0, row_r} + CW'(1);
        out_rsp.neighbour_index     = nbq_r;
        out_rsp.mean_log_divergence = dvq_r;
      end
    end
  end

endmodule

// ===== rtl/ldc_checker.sv =====
// Port-level checker for the divergence curve block, bound to the top level.
`include "assert_macros.svh"
module ldc_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input ldc_pkg::in_req_t  in_req,
  input logic              out_valid,
  input ldc_pkg::out_rsp_t out_rsp
);

  `LDC_ASSERT_NXT(a_read_answers, start && !busy && in_req.op == ldc_pkg::OP_READ, out_valid, "read request gave no result")
  `LDC_ASSERT_NXT(a_last_busy, start && !busy && in_req.op == ldc_pkg::OP_LOAD && in_req.last_sample, busy, "last sample did not start computation")
  `LDC_ASSERT_NXT(a_idle_after, out_valid, !busy, "block not idle after result")
  `LDC_ASSERT_IMP(a_row_num, out_valid && out_rsp.status == ldc_pkg::ST_ROW, out_rsp.row_number != 11'd0, "row result without row number")

endmodule

bind lyapunov_divergence_curve ldc_checker u_ldc_checker (.*);
